/* src/pfgcb_pkg.sv */
// ----------------------------------------------------------------------------
// pfgcb_pkg
// Shared types and constants for the page framebuffer glyph column blit.
// ----------------------------------------------------------------------------
package pfgcb_pkg;

  // Store geometry
  localparam int NUM_COLUMNS = 128;
  localparam int NUM_PAGES   = 4;
  localparam int COL_W       = $clog2(NUM_COLUMNS);
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int NUM_ROWS    = NUM_PAGES * 8;

  // Request types
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Glyph column kinds; the last code has no column shape behind it
  localparam logic [1:0] KIND_TALL16 = 2'd0;
  localparam logic [1:0] KIND_7X8    = 2'd1;
  localparam logic [1:0] KIND_5X7    = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] col_x;
    logic [7:0] row_y;
    logic [1:0] glyph_kind;
    logic [7:0] col_low_byte;
    logic [7:0] col_high_byte;
    logic [1:0] read_page;
    logic [6:0] read_column;
  } pfgcb_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       dropped;
  } pfgcb_res_t;

endpackage

/* src/pfgcb_ram.sv */
// ----------------------------------------------------------------------------
// pfgcb_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pfgcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

/* src/page_framebuffer_glyph_column_blit.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_column_blit
// Monochrome page framebuffer with one-column glyph blit and byte readback.
// ----------------------------------------------------------------------------
// After reset the block clears the store, one column per cycle over all pages
// at once, and holds busy high until all NUM_COLUMNS columns are cleared,
// before the first request is taken. For each request, in the accept cycle
// every page bank is read at the target column, in the next cycle a draw's new
// bytes are merged and written back to all touched pages in parallel, one
// RAM per page. The result appears in the cycle after that on result_o with
// done_o high for exactly one cycle; it cannot be held off, so capture it
// then. busy is low again in the cycle the result is shown, so a new request
// may be accepted while the result of the last one is shown.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_column_blit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  pfgcb_pkg::pfgcb_req_t  req_i,
  output logic                   busy,
  output logic                   done_o,
  output pfgcb_pkg::pfgcb_res_t  result_o
);
  import pfgcb_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_e;

  state_e     state_q;
  logic [COL_W-1:0] clr_q;
  pfgcb_req_t req_q;
  logic       done_q;
  pfgcb_res_t res_q;

  logic             accept;
  logic [COL_W-1:0] addr;
  logic [7:0]       rdata [NUM_PAGES];
  logic [7:0]       wdata [NUM_PAGES];
  logic             wen   [NUM_PAGES];

  // Decoded fields of the held request
  logic        col_ok, row_ok, draw_ok, merge;
  logic [4:0]  page;
  logic [2:0]  sh;
  logic [23:0] seg;
  logic        rd_ok;
  logic [7:0]  rd_byte;
  pfgcb_res_t  res_d;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // RAM address: clear sweep, incoming request, or held request
  always_comb begin
    case (state_q)
      ST_CLEAR: addr = clr_q;
      ST_IDLE: begin
        if (req_i.req_type == REQ_READ) begin
          addr = COL_W'(req_i.read_column);
        end else begin
          addr = req_i.col_x[COL_W-1:0];
        end
      end
      ST_MODIFY: begin
        if (req_q.req_type == REQ_READ) begin
          addr = COL_W'(req_q.read_column);
        end else begin
          addr = req_q.col_x[COL_W-1:0];
        end
      end
      default: addr = '0;
    endcase
  end

  // Draw decode: the column (16 bits for TALL16, else 8) shifted across up to three page bytes
  always_comb begin
    col_ok  = (32'(req_q.col_x) < NUM_COLUMNS);
    row_ok  = (32'(req_q.row_y) < NUM_ROWS);
    page    = req_q.row_y[7:3];
    sh      = req_q.row_y[2:0];
    merge   = (sh != 3'd0);
    draw_ok = (req_q.req_type == REQ_DRAW) && col_ok && row_ok;
    if (req_q.glyph_kind == KIND_TALL16) begin
      seg = {8'd0, req_q.col_high_byte, req_q.col_low_byte} << sh;
    end else begin
      seg = {16'd0, req_q.col_low_byte} << sh;
    end
  end

  // One bank per page, each read then written back at the same column
  for (genvar p = 0; p < NUM_PAGES; p++) begin : g_bank
    logic       hit0, hit1, hit2;
    logic       we1, we2;
    logic [7:0] part;

    always_comb begin
      hit0 = ({1'b0, page} == 6'(p));
      hit1 = ({1'b0, page} + 6'd1 == 6'(p));
      hit2 = ({1'b0, page} + 6'd2 == 6'(p));
      we1  = 1'b0;
      we2  = 1'b0;
      case (req_q.glyph_kind)
        KIND_TALL16: begin
          we1 = 1'b1;
          we2 = merge;
        end
        KIND_7X8: we1 = merge;
        KIND_5X7: we1 = merge && (sh != 3'd1);
        default: ;
      endcase
      part = hit0 ? seg[7:0] : (hit1 ? seg[15:8] : seg[23:16]);
      if (state_q == ST_CLEAR) begin
        wen[p]   = 1'b1;
        wdata[p] = 8'd0;
      end else begin
        wen[p]   = (state_q == ST_MODIFY) && draw_ok
                   && (req_q.glyph_kind != KIND_NONE)
                   && (hit0 || (hit1 && we1) || (hit2 && we2));
        wdata[p] = merge ? (rdata[p] | part) : part;
      end
    end

    pfgcb_ram #(
      .WIDTH (8),
      .DEPTH (NUM_COLUMNS)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (accept || wen[p]),
      .we_i    (wen[p]),
      .addr_i  (addr),
      .wdata_i (wdata[p]),
      .rdata_o (rdata[p])
    );
  end

  // Result of the held request
  always_comb begin
    rd_ok   = (32'(req_q.read_page) < NUM_PAGES)
              && (32'(req_q.read_column) < NUM_COLUMNS);
    rd_byte = rdata[PAGE_W'(req_q.read_page)];
    res_d   = '0;
    if (req_q.req_type == REQ_READ) begin
      res_d.read_byte = rd_ok ? rd_byte : 8'd0;
    end else begin
      res_d.dropped = !(col_ok && row_ok);
    end
  end

  // Control state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= (state_q == ST_MODIFY);
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + COL_W'(1);
          if (clr_q == COL_W'(NUM_COLUMNS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          res_q   <= res_d;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Held request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
